// ===== rtl/core/cdb_pkg.sv =====
// Shared types and constants for the decode and branch unit.
// Used by the front decoder, the entry queue, the back end and the top level.
`default_nettype none

package cdb_pkg;

  // Default program counter width and depth of the decoded-word queue
  localparam int CDB_PC_WIDTH    = 16;
  localparam int CDB_QUEUE_DEPTH = 2;
  localparam int CDB_CNT_W       = $clog2(CDB_QUEUE_DEPTH + 1);

  // Stream widths: fields packed from bit 0 up, zero-padded to whole bytes
  localparam int CDB_IN_BITS   = 36;
  localparam int CDB_IN_BYTES  = (CDB_IN_BITS + 7) / 8;
  localparam int CDB_OUT_BITS  = 51;
  localparam int CDB_OUT_BYTES = (CDB_OUT_BITS + 7) / 8;

  // How the program counter moves for one word
  localparam logic [1:0] PC_SEQ  = 2'd0;
  localparam logic [1:0] PC_JAL  = 2'd1;
  localparam logic [1:0] PC_COND = 2'd2;

  // One decoded word as it travels from front to back
  typedef struct packed {
    logic        nop;        // all-zero instruction
    logic        ctrl_set;   // control fields are assigned
    logic [5:0]  alu_op;
    logic [3:0]  selects;
    logic [3:0]  enables;
    logic [1:0]  wb_sel;
    logic        addr_hold;  // keep the previous address-path selects
    logic [2:0]  addr_sel;
    logic [15:0] regs_imm;   // src [3:0], dest [7:4], imm [15:8]
    logic [1:0]  pc_op;
    logic        cond_undef;
    logic        cond_ok;
    logic        cond_jump;  // taken condition loads the target, else adds disp
    logic [15:0] target;
  } cdb_entry_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic [CDB_CNT_W-1:0] count;
    logic                 push;
    logic                 pop;
  } cdb_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/core/cdb_front.sv =====
// Front decoder: classifies one instruction word into a decoded entry.
// Depends on cdb_pkg for the entry type and the pc-move codes.
`default_nettype none

module cdb_front (
  input  wire logic [15:0]        instruction,
  input  wire logic [3:0]         flags,
  input  wire logic [15:0]        target_value,
  output cdb_pkg::cdb_entry_t     entry
);
  import cdb_pkg::*;

  // Opcodes
  localparam logic [3:0] OP_REGREG  = 4'd0;
  localparam logic [3:0] OP_AND_I   = 4'd1;
  localparam logic [3:0] OP_OR_I    = 4'd2;
  localparam logic [3:0] OP_XOR_I   = 4'd3;
  localparam logic [3:0] OP_MEM_JMP = 4'd4;
  localparam logic [3:0] OP_ADD_I   = 4'd5;
  localparam logic [3:0] OP_SHIFT   = 4'd8;
  localparam logic [3:0] OP_SUB_I   = 4'd9;
  localparam logic [3:0] OP_CMP_I   = 4'd11;
  localparam logic [3:0] OP_BCOND   = 4'd12;
  localparam logic [3:0] OP_MOV_I   = 4'd13;
  localparam logic [3:0] OP_LUI     = 4'd15;

  // Extensions of the register-register and memory/jump groups
  localparam logic [3:0] EXT_AND   = 4'd1;
  localparam logic [3:0] EXT_OR    = 4'd2;
  localparam logic [3:0] EXT_XOR   = 4'd3;
  localparam logic [3:0] EXT_ADD   = 4'd5;
  localparam logic [3:0] EXT_SUB   = 4'd9;
  localparam logic [3:0] EXT_CMP   = 4'd11;
  localparam logic [3:0] EXT_MOV   = 4'd13;
  localparam logic [3:0] EXT_LOAD  = 4'd0;
  localparam logic [3:0] EXT_STORE = 4'd4;
  localparam logic [3:0] EXT_JAL   = 4'd8;
  localparam logic [3:0] EXT_JCOND = 4'd12;

  // Shift kinds
  localparam logic [2:0] SH_LSH  = 3'd0;
  localparam logic [2:0] SH_ASH  = 3'd1;
  localparam logic [2:0] SH_LSHI = 3'd2;
  localparam logic [2:0] SH_ASHI = 3'd3;

  // Condition codes
  localparam logic [3:0] COND_EQ = 4'd0;
  localparam logic [3:0] COND_NE = 4'd1;
  localparam logic [3:0] COND_CS = 4'd2;
  localparam logic [3:0] COND_CC = 4'd3;
  localparam logic [3:0] COND_GT = 4'd6;
  localparam logic [3:0] COND_LE = 4'd7;
  localparam logic [3:0] COND_LT = 4'd12;
  localparam logic [3:0] COND_GE = 4'd13;

  // ALU codes
  localparam logic [5:0] ALU_ADD_RR  = 6'd1;
  localparam logic [5:0] ALU_ADD_RI  = 6'd2;
  localparam logic [5:0] ALU_SUB_RR  = 6'd3;
  localparam logic [5:0] ALU_SUB_RI  = 6'd4;
  localparam logic [5:0] ALU_CMP_RR  = 6'd5;
  localparam logic [5:0] ALU_CMP_RI  = 6'd6;
  localparam logic [5:0] ALU_AND_RR  = 6'd7;
  localparam logic [5:0] ALU_AND_RI  = 6'd8;
  localparam logic [5:0] ALU_OR_RR   = 6'd9;
  localparam logic [5:0] ALU_OR_RI   = 6'd10;
  localparam logic [5:0] ALU_XOR_RR  = 6'd11;
  localparam logic [5:0] ALU_XOR_RI  = 6'd12;
  localparam logic [5:0] ALU_MOV_RR  = 6'd13;
  localparam logic [5:0] ALU_MOV_RI  = 6'd14;
  localparam logic [5:0] ALU_LSHI    = 6'd15;
  localparam logic [5:0] ALU_LSH     = 6'd16;
  localparam logic [5:0] ALU_ASHI    = 6'd17;
  localparam logic [5:0] ALU_ASH     = 6'd18;
  localparam logic [5:0] ALU_LUI     = 6'd19;
  localparam logic [5:0] ALU_LOAD    = 6'd20;
  localparam logic [5:0] ALU_STORE   = 6'd21;
  localparam logic [5:0] ALU_BCOND   = 6'd22;
  localparam logic [5:0] ALU_JCOND   = 6'd30;
  localparam logic [5:0] ALU_JAL     = 6'b100110;
  localparam logic [5:0] ALU_NOP     = 6'b100111;

  // Operand selects
  localparam logic [3:0] SEL_NONE  = 4'd0;
  localparam logic [3:0] SEL_MEM   = 4'd2;
  localparam logic [3:0] SEL_RI    = 4'd4;
  localparam logic [3:0] SEL_RR    = 4'd6;
  localparam logic [3:0] SEL_RI_HI = 4'd12;
  localparam logic [3:0] SEL_LUI   = 4'd13;
  localparam logic [3:0] SEL_SHI   = 4'd14;

  // Access enables
  localparam logic [3:0] EN_NONE  = 4'd0;
  localparam logic [3:0] EN_W     = 4'd1;
  localparam logic [3:0] EN_R     = 4'd2;
  localparam logic [3:0] EN_RW    = 4'd3;
  localparam logic [3:0] EN_LOAD  = 4'd7;
  localparam logic [3:0] EN_STORE = 4'd10;

  // Writeback and address-path selects
  localparam logic [1:0] WB_ALU = 2'd0;
  localparam logic [1:0] WB_MEM = 2'd1;
  localparam logic [1:0] WB_PC  = 2'd2;
  localparam logic [2:0] AP_NONE = 3'd0;
  localparam logic [2:0] AP_LOAD = 3'd2;
  localparam logic [2:0] AP_ALU  = 3'd6;
  localparam logic [2:0] AP_PC   = 3'd7;

  logic [3:0] op;
  logic [3:0] cond;
  logic [3:0] ext;
  logic [3:0] m1;
  logic       flag_z;
  logic       flag_n;
  logic       flag_c;
  logic       cond_def;
  logic       cond_true;
  logic [2:0] cond_idx;

  assign op     = instruction[15:12];
  assign cond   = instruction[11:8];
  assign ext    = instruction[7:4];
  assign m1     = {3'b000, ~instruction[7]};
  assign flag_z = flags[3];
  assign flag_n = flags[1];
  assign flag_c = flags[0];

  // Evaluate the condition field against the flags
  always_comb begin
    cond_def  = 1'b1;
    cond_true = 1'b0;
    cond_idx  = 3'd0;
    case (cond)
      COND_EQ: begin cond_idx = 3'd0; cond_true = flag_z;             end
      COND_NE: begin cond_idx = 3'd1; cond_true = !flag_z;            end
      COND_GE: begin cond_idx = 3'd2; cond_true = flag_z || flag_n;   end
      COND_CS: begin cond_idx = 3'd3; cond_true = flag_c;             end
      COND_CC: begin cond_idx = 3'd4; cond_true = !flag_c;            end
      COND_GT: begin cond_idx = 3'd5; cond_true = flag_n;             end
      COND_LE: begin cond_idx = 3'd6; cond_true = !flag_n;            end
      COND_LT: begin cond_idx = 3'd7; cond_true = !flag_n && !flag_z; end
      default: cond_def = 1'b0;
    endcase
  end

  // Decode control fields and the pc move
  always_comb begin
    entry            = '0;
    entry.nop        = (instruction == 16'h0000);
    entry.regs_imm   = {instruction[7:0], cond, instruction[3:0]};
    entry.target     = target_value;
    entry.cond_undef = !cond_def;
    entry.cond_ok    = cond_true;
    entry.cond_jump  = (op == OP_MEM_JMP);
    entry.pc_op      = PC_SEQ;
    entry.selects    = SEL_RR;
    entry.enables    = EN_RW;
    entry.wb_sel     = WB_ALU;
    entry.addr_sel   = AP_ALU;

    case (op)
      OP_REGREG: begin
        entry.ctrl_set = 1'b1;
        case (ext)
          EXT_ADD: begin entry.alu_op = ALU_ADD_RR; entry.addr_sel = AP_NONE; end
          EXT_SUB: entry.alu_op = ALU_SUB_RR;
          EXT_AND: entry.alu_op = ALU_AND_RR;
          EXT_CMP: begin entry.alu_op = ALU_CMP_RR; entry.enables = EN_R; end
          EXT_OR:  entry.alu_op = ALU_OR_RR;
          EXT_XOR: entry.alu_op = ALU_XOR_RR;
          EXT_MOV: entry.alu_op = ALU_MOV_RR;
          default: entry.ctrl_set = 1'b0;
        endcase
      end
      OP_ADD_I: begin
        entry.ctrl_set = 1'b1; entry.alu_op = ALU_ADD_RI; entry.selects = m1 | SEL_RI;
      end
      OP_SUB_I: begin
        entry.ctrl_set = 1'b1; entry.alu_op = ALU_SUB_RI; entry.selects = m1 | SEL_RI;
      end
      OP_AND_I: begin
        entry.ctrl_set = 1'b1; entry.alu_op = ALU_AND_RI; entry.selects = m1 | SEL_RI;
      end
      OP_CMP_I: begin
        entry.ctrl_set = 1'b1; entry.alu_op = ALU_CMP_RI; entry.selects = m1 | SEL_RI;
        entry.enables  = EN_R;
      end
      OP_OR_I: begin
        entry.ctrl_set = 1'b1; entry.alu_op = ALU_OR_RI; entry.selects = m1 | SEL_RI_HI;
      end
      OP_XOR_I: begin
        entry.ctrl_set = 1'b1; entry.alu_op = ALU_XOR_RI; entry.selects = m1 | SEL_RI_HI;
      end
      OP_MOV_I: begin
        entry.ctrl_set = 1'b1; entry.alu_op = ALU_MOV_RI; entry.selects = m1 | SEL_RI_HI;
      end
      OP_SHIFT: begin
        entry.ctrl_set = 1'b1;
        case (instruction[7:5])
          SH_LSH:  begin entry.alu_op = ALU_LSH;  entry.selects = m1 | SEL_RI_HI; end
          SH_ASH:  begin entry.alu_op = ALU_ASH;  entry.selects = m1 | SEL_RI_HI; end
          SH_LSHI: begin entry.alu_op = ALU_LSHI; entry.selects = m1 | SEL_SHI;   end
          SH_ASHI: begin entry.alu_op = ALU_ASHI; entry.selects = m1 | SEL_SHI;   end
          default: entry.ctrl_set = 1'b0;
        endcase
      end
      OP_MEM_JMP: begin
        case (ext)
          EXT_LOAD: begin
            entry.ctrl_set = 1'b1; entry.alu_op = ALU_LOAD; entry.selects = m1 | SEL_MEM;
            entry.enables  = EN_LOAD; entry.wb_sel = WB_MEM; entry.addr_sel = AP_LOAD;
          end
          EXT_STORE: begin
            entry.ctrl_set = 1'b1; entry.alu_op = ALU_STORE; entry.selects = m1 | SEL_MEM;
            entry.enables  = EN_STORE; entry.addr_sel = AP_NONE;
          end
          EXT_JAL: begin
            entry.ctrl_set = 1'b1; entry.alu_op = ALU_JAL; entry.selects = m1 | SEL_MEM;
            entry.wb_sel   = WB_PC; entry.addr_sel = AP_PC;
            entry.pc_op    = PC_JAL;
          end
          EXT_JCOND: begin
            entry.pc_op     = PC_COND;
            entry.ctrl_set  = cond_def;
            entry.alu_op    = ALU_JCOND + {3'b000, cond_idx};
            entry.selects   = SEL_NONE;
            entry.enables   = EN_R;
            entry.wb_sel    = WB_PC;
            entry.addr_sel  = AP_PC;
            // jump on carry set leaves the address path alone
            entry.addr_hold = (cond == COND_CS);
          end
          default: ;
        endcase
      end
      OP_BCOND: begin
        entry.pc_op    = PC_COND;
        entry.ctrl_set = cond_def;
        entry.alu_op   = ALU_BCOND + {3'b000, cond_idx};
        entry.selects  = SEL_NONE;
        entry.enables  = EN_NONE;
        entry.wb_sel   = WB_PC;
        entry.addr_sel = AP_PC;
      end
      OP_LUI: begin
        entry.ctrl_set = 1'b1; entry.alu_op = ALU_LUI; entry.selects = SEL_LUI;
        entry.enables  = EN_W; entry.wb_sel = WB_PC; entry.addr_sel = AP_PC;
      end
      default: ;
    endcase

    // an all-zero word sets the NOP ALU code, clears ctrl_set, selects and enables and keeps the rest
    if (entry.nop) begin
      entry.ctrl_set = 1'b0;
      entry.alu_op   = ALU_NOP;
      entry.selects  = SEL_NONE;
      entry.enables  = EN_NONE;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cdb_queue.sv =====
// Short queue of decoded words between the front decoder and the back end.
// Depends on cdb_pkg for the entry and status types and the queue depth.
`default_nettype none

module cdb_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push_valid,
  output logic                     push_ready,
  input  wire cdb_pkg::cdb_entry_t push_data,
  output logic                     pop_valid,
  input  wire logic                pop_ready,
  output cdb_pkg::cdb_entry_t      pop_data,
  output cdb_pkg::cdb_qstat_t      status
);
  import cdb_pkg::*;

  localparam int PTR_W = (CDB_QUEUE_DEPTH > 1) ? $clog2(CDB_QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0]     LAST_SLOT = PTR_W'(CDB_QUEUE_DEPTH - 1);
  localparam logic [CDB_CNT_W-1:0] FULL_CNT  = CDB_CNT_W'(CDB_QUEUE_DEPTH);

  cdb_entry_t           slots [CDB_QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CDB_CNT_W-1:0] count;
  logic                 push;
  logic                 pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  assign status.count = count;
  assign status.push  = push;
  assign status.pop   = pop;

  // Store a pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cdb_back.sv =====
// Back end: applies decoded words to the held control state and the program
// counter, and drives the output register. Depends on cdb_pkg.
`default_nettype none

module cdb_back #(
  parameter int PC_WIDTH = cdb_pkg::CDB_PC_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              pop_valid,
  output logic                                   pop_ready,
  input  wire cdb_pkg::cdb_entry_t               entry,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [8*cdb_pkg::CDB_OUT_BYTES-1:0]    m_tdata
);
  import cdb_pkg::*;

  // Held state; it doubles as the output payload register
  logic [PC_WIDTH-1:0] program_counter;
  logic                started;
  logic [5:0]          alu_op;
  logic [3:0]          selects;
  logic [3:0]          enables;
  logic [15:0]         regs_imm;
  logic [1:0]          wb_sel;
  logic [2:0]          addr_sel;
  logic [15:0]         fetch_address;

  logic [PC_WIDTH-1:0] pc_next;
  logic [PC_WIDTH-1:0] fetch_next;
  logic [PC_WIDTH-1:0] seq_base;
  logic [PC_WIDTH-1:0] target_pc;
  logic [PC_WIDTH-1:0] disp_pc;
  logic                step;

  assign pop_ready = !m_tvalid || m_tready;
  assign step      = pop_valid && pop_ready;
  assign seq_base  = started ? program_counter : '0;
  assign target_pc = PC_WIDTH'(entry.target);
  assign disp_pc   = PC_WIDTH'(signed'(entry.regs_imm[15:8]));

  // Work out the next program counter and the address fetched
  always_comb begin
    pc_next    = program_counter;
    fetch_next = program_counter;
    case (entry.pc_op)
      PC_JAL: begin
        fetch_next = target_pc;
        pc_next    = target_pc + 1'b1;
      end
      PC_COND: begin
        if (!entry.cond_undef) begin
          if (!entry.cond_ok) begin
            pc_next = program_counter + 1'b1;
          end else if (entry.cond_jump) begin
            pc_next = target_pc;
          end else begin
            pc_next = program_counter + disp_pc;
          end
          fetch_next = pc_next;
        end
      end
      default: begin
        fetch_next = seq_base;
        pc_next    = seq_base + 1'b1;
      end
    endcase
  end

  // Update held state and the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid        <= 1'b0;
      program_counter <= '0;
      started         <= 1'b0;
      alu_op          <= '0;
      selects         <= '0;
      enables         <= '0;
      regs_imm        <= '0;
      wb_sel          <= '0;
      addr_sel        <= '0;
      fetch_address   <= '0;
    end else begin
      if (step) begin
        m_tvalid        <= 1'b1;
        program_counter <= pc_next;
        fetch_address   <= 16'(fetch_next);
        if (entry.pc_op == PC_SEQ) begin
          started <= 1'b1;
        end
        if (entry.nop || entry.ctrl_set) begin
          alu_op  <= entry.alu_op;
          selects <= entry.selects;
          enables <= entry.enables;
        end
        if (entry.ctrl_set) begin
          wb_sel <= entry.wb_sel;
          if (!entry.addr_hold) begin
            addr_sel <= entry.addr_sel;
          end
        end
        if (!entry.nop) begin
          regs_imm <= entry.regs_imm;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {(8*CDB_OUT_BYTES - CDB_OUT_BITS)'(0), addr_sel, wb_sel,
                    regs_imm[15:8], regs_imm[7:4], regs_imm[3:0],
                    enables, selects, alu_op, fetch_address};

endmodule

`default_nettype wire

// ===== rtl/core/cpu_decode_and_branch_unit.sv =====
// Top level of the instruction decode and branch unit.
// Depends on cdb_pkg, cdb_front, cdb_queue and cdb_back.
//
// Usage:
//   s_* channel carries one instruction word per transfer, m_* channel one
//   decoded result word per instruction, in order, one for one.
//   A word moves at a rising edge with tvalid and tready both high.
//   Path: a taken word is queued at the accepting edge and moves into the
//   output register once the back end can take it (output register empty
//   or its result being taken).
//   Throughput: one word per cycle while m_tready stays high.
//   Stall: when m_tready is low the result holds, the back end stops, and
//   the two-entry queue absorbs further decoded words before s_tready drops.
//   Reset (rst, synchronous): queue empty, pc, start flag and all held
//   control fields cleared; no result is offered until a word arrives.
`default_nettype none

module cpu_decode_and_branch_unit #(
  parameter int PC_WIDTH = cdb_pkg::CDB_PC_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // [15:0] instruction, [19:16] flags, [35:20] target_value, rest zero
  input  wire logic [8*cdb_pkg::CDB_IN_BYTES-1:0]  s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [15:0] fetch_address, [21:16] alu_op, [25:22] operand_selects,
  // [29:26] access_enables, [33:30] source_reg, [37:34] dest_reg,
  // [45:38] immediate, [47:46] writeback_select,
  // [50:48] address_path_selects, rest zero
  output logic [8*cdb_pkg::CDB_OUT_BYTES-1:0]  m_tdata
);
  import cdb_pkg::*;

  cdb_entry_t front_entry;
  cdb_entry_t back_entry;
  cdb_qstat_t q_stat;
  logic       q_valid;
  logic       q_ready;

  // Classify the incoming word
  cdb_front u_front (
    .instruction  (s_tdata[15:0]),
    .flags        (s_tdata[19:16]),
    .target_value (s_tdata[35:20]),
    .entry        (front_entry)
  );

  // Hold decoded words between front and back
  cdb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (s_tvalid),
    .push_ready (s_tready),
    .push_data  (front_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (back_entry),
    .status     (q_stat)
  );

  // Carry out decoded words
  cdb_back #(
    .PC_WIDTH (PC_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .entry     (back_entry),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Queue never overfills
  assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= CDB_CNT_W'(CDB_QUEUE_DEPTH))
    else $error("decoded-word queue overfilled");

  // A waiting word reaches an idle output register at the next edge
  assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid && q_valid) |=> m_tvalid)
    else $error("queued word not moved to the output");

  // A word taken while none is popped to the back end grows the queue by one
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !q_stat.pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
    else $error("queue count lost an accepted word");

  // The output stalls only while the back end holds off the queue
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !q_stat.pop)
    else $error("back end advanced during an output stall");

endmodule

`default_nettype wire

// ===== tb/sv/decode_result_check.sv =====
`timescale 1ns / 100ps
// Instruction field codes shared by the stimulus and the decode predictor, and the
// module that predicts every result word of the decode and branch unit and checks it.
// Depends on cdb_pkg for the stream widths.

package isa_fields_pkg;

  // Major opcodes, instruction bits [15:12]
  localparam logic [3:0] OPC_REG   = 4'd0;
  localparam logic [3:0] OPC_ANDI  = 4'd1;
  localparam logic [3:0] OPC_ORI   = 4'd2;
  localparam logic [3:0] OPC_XORI  = 4'd3;
  localparam logic [3:0] OPC_MEM   = 4'd4;
  localparam logic [3:0] OPC_ADDI  = 4'd5;
  localparam logic [3:0] OPC_SPARE = 4'd6;
  localparam logic [3:0] OPC_SHIFT = 4'd8;
  localparam logic [3:0] OPC_ADDUI = 4'd9;
  localparam logic [3:0] OPC_CMPI  = 4'd11;
  localparam logic [3:0] OPC_BCOND = 4'd12;
  localparam logic [3:0] OPC_MOVI  = 4'd13;
  localparam logic [3:0] OPC_LUI   = 4'd15;

  // Register-form extensions, bits [7:4]
  localparam logic [3:0] EXT_AND       = 4'd1;
  localparam logic [3:0] EXT_OR        = 4'd2;
  localparam logic [3:0] EXT_XOR       = 4'd3;
  localparam logic [3:0] EXT_ADD       = 4'd5;
  localparam logic [3:0] EXT_REG_SPARE = 4'd7;
  localparam logic [3:0] EXT_ADDU      = 4'd9;
  localparam logic [3:0] EXT_CMP       = 4'd11;
  localparam logic [3:0] EXT_MOV       = 4'd13;

  // Memory and jump extensions under OPC_MEM
  localparam logic [3:0] EXT_LOAD  = 4'd0;
  localparam logic [3:0] EXT_STOR  = 4'd4;
  localparam logic [3:0] EXT_JAL   = 4'd8;
  localparam logic [3:0] EXT_JCOND = 4'd12;

  // Shift kinds, bits [7:5]
  localparam logic [2:0] SHK_LSH   = 3'd0;
  localparam logic [2:0] SHK_LSHI  = 3'd1;
  localparam logic [2:0] SHK_ASH   = 3'd2;
  localparam logic [2:0] SHK_ASHI  = 3'd3;
  localparam logic [2:0] SHK_SPARE = 3'd4;

  // Branch and jump conditions, bits [11:8]
  localparam logic [3:0] COND_EQ    = 4'd0;
  localparam logic [3:0] COND_NE    = 4'd1;
  localparam logic [3:0] COND_CS    = 4'd2;
  localparam logic [3:0] COND_CC    = 4'd3;
  localparam logic [3:0] COND_GT    = 4'd6;
  localparam logic [3:0] COND_LE    = 4'd7;
  localparam logic [3:0] COND_SPARE = 4'd9;
  localparam logic [3:0] COND_LT    = 4'd12;
  localparam logic [3:0] COND_GE    = 4'd13;

  localparam logic [3:0] LEGAL_OPCS [12] = '{OPC_REG, OPC_ANDI, OPC_ORI, OPC_XORI, OPC_MEM,
    OPC_ADDI, OPC_SHIFT, OPC_ADDUI, OPC_CMPI, OPC_BCOND, OPC_MOVI, OPC_LUI};
  localparam logic [3:0] IMM_OPCS [7] = '{OPC_ADDI, OPC_ADDUI, OPC_ANDI, OPC_CMPI, OPC_ORI,
    OPC_XORI, OPC_MOVI};
  localparam logic [3:0] REG_EXTS [7] = '{EXT_ADD, EXT_ADDU, EXT_AND, EXT_CMP, EXT_OR,
    EXT_XOR, EXT_MOV};
  localparam logic [3:0] MEM_EXTS [4] = '{EXT_LOAD, EXT_STOR, EXT_JAL, EXT_JCOND};
  localparam logic [3:0] DEFINED_CONDS [8] = '{COND_EQ, COND_NE, COND_CS, COND_CC, COND_GT,
    COND_LE, COND_LT, COND_GE};

endpackage

module decode_result_check (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  input  wire logic                               s_tready,
  input  wire logic [8*cdb_pkg::CDB_IN_BYTES-1:0]  s_tdata,
  input  wire logic                               m_tvalid,
  input  wire logic                               m_tready,
  input  wire logic [8*cdb_pkg::CDB_OUT_BYTES-1:0] m_tdata,
  output int                                      errors,
  output int                                      pending
);
  import isa_fields_pkg::*;

  // ALU control codes
  localparam logic [5:0] ALU_ADD   = 6'd1;
  localparam logic [5:0] ALU_ADDI  = 6'd2;
  localparam logic [5:0] ALU_ADDU  = 6'd3;
  localparam logic [5:0] ALU_ADDUI = 6'd4;
  localparam logic [5:0] ALU_CMP   = 6'd5;
  localparam logic [5:0] ALU_CMPI  = 6'd6;
  localparam logic [5:0] ALU_AND   = 6'd7;
  localparam logic [5:0] ALU_ANDI  = 6'd8;
  localparam logic [5:0] ALU_OR    = 6'd9;
  localparam logic [5:0] ALU_ORI   = 6'd10;
  localparam logic [5:0] ALU_XOR   = 6'd11;
  localparam logic [5:0] ALU_XORI  = 6'd12;
  localparam logic [5:0] ALU_MOV   = 6'd13;
  localparam logic [5:0] ALU_MOVI  = 6'd14;
  localparam logic [5:0] ALU_ASH   = 6'd15;
  localparam logic [5:0] ALU_LSH   = 6'd16;
  localparam logic [5:0] ALU_ASHI  = 6'd17;
  localparam logic [5:0] ALU_LSHI  = 6'd18;
  localparam logic [5:0] ALU_LUI   = 6'd19;
  localparam logic [5:0] ALU_LOAD  = 6'd20;
  localparam logic [5:0] ALU_STOR  = 6'd21;
  localparam logic [5:0] ALU_BCOND = 6'd22;  // plus the condition slot
  localparam logic [5:0] ALU_JCOND = 6'd30;  // plus the condition slot
  localparam logic [5:0] ALU_JAL   = 6'b100110;
  localparam logic [5:0] ALU_NOP   = 6'b100111;

  // Access enable bits and writeback sources
  localparam logic [3:0] EN_RF_WR = 4'b0001;
  localparam logic [3:0] EN_RF_RD = 4'b0010;
  localparam logic [3:0] EN_DM_RD = 4'b0100;
  localparam logic [3:0] EN_DM_WR = 4'b1000;
  localparam logic [1:0] WB_ALU = 2'd0;
  localparam logic [1:0] WB_MEM = 2'd1;
  localparam logic [1:0] WB_PC  = 2'd2;
  localparam int NO_SLOT = 8;

  // Result word, fetch address in the lowest bits
  typedef struct packed {
    logic [2:0]  addr_sel;
    logic [1:0]  wb_sel;
    logic [7:0]  imm;
    logic [3:0]  dst;
    logic [3:0]  src;
    logic [3:0]  enables;
    logic [3:0]  selects;
    logic [5:0]  alu_op;
    logic [15:0] fetch;
  } dec_word_t;

  // Predicted unit state
  logic [15:0] pc_q;
  logic        started_q;
  logic [5:0]  alu_q;
  logic [3:0]  sel_q;
  logic [3:0]  en_q;
  logic [3:0]  src_q;
  logic [3:0]  dst_q;
  logic [7:0]  imm_q;
  logic [1:0]  wb_q;
  logic [2:0]  addr_q;

  dec_word_t expected_words [$];

  function automatic int cond_slot(input logic [3:0] c);
    case (c)
      COND_EQ: return 0;
      COND_NE: return 1;
      COND_GE: return 2;
      COND_CS: return 3;
      COND_CC: return 4;
      COND_GT: return 5;
      COND_LE: return 6;
      COND_LT: return 7;
      default: return NO_SLOT;
    endcase
  endfunction

  // 1 taken, 0 not taken, -1 undefined condition; flags are Z F N C from bit 3 down
  function automatic int cond_holds(input logic [3:0] c, input logic [3:0] f);
    case (c)
      COND_EQ: return int'(f[3]);
      COND_NE: return int'(!f[3]);
      COND_GE: return int'(f[3] || f[1]);
      COND_CS: return int'(f[0]);
      COND_CC: return int'(!f[0]);
      COND_GT: return int'(f[1]);
      COND_LE: return int'(!f[1]);
      COND_LT: return int'(!f[1] && !f[3]);
      default: return -1;
    endcase
  endfunction

  task automatic set_controls(input logic [5:0] alu, input logic [3:0] sel,
                              input logic [3:0] en, input logic [1:0] wb,
                              input logic keep_addr, input logic [2:0] addr);
    alu_q = alu;
    sel_q = sel;
    en_q  = en;
    wb_q  = wb;
    if (!keep_addr) begin
      addr_q = addr;
    end
  endtask

  // Decode one instruction, move the pc and form the result word
  task automatic decode_and_advance(input logic [15:0] ins, input logic [3:0] flg,
                                    input logic [15:0] tgt, output dec_word_t res);
    logic [3:0]  opc;
    logic [3:0]  cnd;
    logic [3:0]  ext;
    logic [3:0]  m1;
    logic [15:0] fetch;
    int          slot;
    int          taken;
    opc  = ins[15:12];
    cnd  = ins[11:8];
    ext  = ins[7:4];
    m1   = {3'b000, ~ins[7]};
    slot = cond_slot(cnd);

    if (ins == 16'h0000) begin
      alu_q = ALU_NOP;
      sel_q = 4'b0000;
      en_q  = 4'b0000;
    end else begin
      src_q = ins[3:0];
      dst_q = cnd;
      imm_q = ins[7:0];
      case (opc)
        OPC_REG: begin
          case (ext)
            EXT_ADD:  set_controls(ALU_ADD, 4'b0110, EN_RF_WR | EN_RF_RD, WB_ALU, 1'b0, 3'd0);
            EXT_ADDU: set_controls(ALU_ADDU, 4'b0110, EN_RF_WR | EN_RF_RD, WB_ALU, 1'b0, 3'd6);
            EXT_AND:  set_controls(ALU_AND, 4'b0110, EN_RF_WR | EN_RF_RD, WB_ALU, 1'b0, 3'd6);
            EXT_CMP:  set_controls(ALU_CMP, 4'b0110, EN_RF_RD, WB_ALU, 1'b0, 3'd6);
            EXT_OR:   set_controls(ALU_OR, 4'b0110, EN_RF_WR | EN_RF_RD, WB_ALU, 1'b0, 3'd6);
            EXT_XOR:  set_controls(ALU_XOR, 4'b0110, EN_RF_WR | EN_RF_RD, WB_ALU, 1'b0, 3'd6);
            EXT_MOV:  set_controls(ALU_MOV, 4'b0110, EN_RF_WR | EN_RF_RD, WB_ALU, 1'b0, 3'd6);
            default: ;
          endcase
        end
        OPC_ADDI:  set_controls(ALU_ADDI, m1 | 4'b0100, EN_RF_WR | EN_RF_RD, WB_ALU, 1'b0, 3'd6);
        OPC_ADDUI: set_controls(ALU_ADDUI, m1 | 4'b0100, EN_RF_WR | EN_RF_RD, WB_ALU, 1'b0, 3'd6);
        OPC_ANDI:  set_controls(ALU_ANDI, m1 | 4'b0100, EN_RF_WR | EN_RF_RD, WB_ALU, 1'b0, 3'd6);
        OPC_CMPI:  set_controls(ALU_CMPI, m1 | 4'b0100, EN_RF_RD, WB_ALU, 1'b0, 3'd6);
        OPC_ORI:   set_controls(ALU_ORI, m1 | 4'b1100, EN_RF_WR | EN_RF_RD, WB_ALU, 1'b0, 3'd6);
        OPC_XORI:  set_controls(ALU_XORI, m1 | 4'b1100, EN_RF_WR | EN_RF_RD, WB_ALU, 1'b0, 3'd6);
        OPC_MOVI:  set_controls(ALU_MOVI, m1 | 4'b1100, EN_RF_WR | EN_RF_RD, WB_ALU, 1'b0, 3'd6);
        OPC_SHIFT: begin
          case (ins[7:5])
            SHK_LSH:  set_controls(ALU_LSH, m1 | 4'b1100, EN_RF_WR | EN_RF_RD, WB_ALU, 1'b0, 3'd6);
            SHK_LSHI: set_controls(ALU_LSHI, m1 | 4'b1100, EN_RF_WR | EN_RF_RD, WB_ALU, 1'b0, 3'd6);
            SHK_ASH:  set_controls(ALU_ASH, m1 | 4'b1110, EN_RF_WR | EN_RF_RD, WB_ALU, 1'b0, 3'd6);
            SHK_ASHI: set_controls(ALU_ASHI, m1 | 4'b1110, EN_RF_WR | EN_RF_RD, WB_ALU, 1'b0, 3'd6);
            default: ;
          endcase
        end
        OPC_MEM: begin
          if (ext == EXT_LOAD) begin
            set_controls(ALU_LOAD, m1 | 4'b0010, EN_RF_WR | EN_RF_RD | EN_DM_RD, WB_MEM, 1'b0,
                         3'd2);
          end else if (ext == EXT_STOR) begin
            set_controls(ALU_STOR, m1 | 4'b0010, EN_RF_RD | EN_DM_WR, WB_ALU, 1'b0, 3'd0);
          end else if (ext == EXT_JAL) begin
            set_controls(ALU_JAL, m1 | 4'b0010, EN_RF_WR | EN_RF_RD, WB_PC, 1'b0, 3'd7);
          end else if (ext == EXT_JCOND && slot != NO_SLOT) begin
            // jump on carry set leaves the address-path selects alone
            set_controls(ALU_JCOND + 6'(slot), 4'b0000, EN_RF_RD, WB_PC, cnd == COND_CS, 3'd7);
          end
        end
        OPC_BCOND: begin
          if (slot != NO_SLOT) begin
            set_controls(ALU_BCOND + 6'(slot), 4'b0000, 4'b0000, WB_PC, 1'b0, 3'd7);
          end
        end
        OPC_LUI: set_controls(ALU_LUI, 4'b1101, EN_RF_WR, WB_PC, 1'b0, 3'd7);
        default: ;
      endcase
    end

    // Program counter
    if (opc == OPC_MEM && ext == EXT_JAL) begin
      fetch = tgt;
      pc_q  = tgt + 16'd1;
    end else if ((opc == OPC_MEM && ext == EXT_JCOND) || opc == OPC_BCOND) begin
      taken = cond_holds(cnd, flg);
      if (taken > 0) begin
        if (opc == OPC_MEM) begin
          pc_q = tgt;
        end else begin
          pc_q = pc_q + {{8{ins[7]}}, ins[7:0]};
        end
      end else if (taken == 0) begin
        pc_q = pc_q + 16'd1;
      end
      fetch = pc_q;
    end else begin
      if (!started_q) begin
        pc_q      = 16'h0000;
        started_q = 1'b1;
      end
      fetch = pc_q;
      pc_q  = pc_q + 16'd1;
    end

    res = '{addr_sel: addr_q, wb_sel: wb_q, imm: imm_q, dst: dst_q, src: src_q,
            enables: en_q, selects: sel_q, alu_op: alu_q, fetch: fetch};
  endtask

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  // Predict on every accepted instruction word, compare on every accepted result word
  always @(posedge clk) begin
    dec_word_t want;
    dec_word_t got;
    if (rst) begin
      pc_q      = '0;
      started_q = 1'b0;
      alu_q     = '0;
      sel_q     = '0;
      en_q      = '0;
      src_q     = '0;
      dst_q     = '0;
      imm_q     = '0;
      wb_q      = '0;
      addr_q    = '0;
      errors    = 0;
      expected_words.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        decode_and_advance(s_tdata[15:0], s_tdata[19:16], s_tdata[35:20], want);
        expected_words.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = dec_word_t'(m_tdata[$bits(dec_word_t)-1:0]);
        if (expected_words.size() == 0) begin
          $display("%0t ns: result word with none expected, actual %h", $time, got);
          errors++;
        end else begin
          want = expected_words.pop_front();
          check_field("fetch_address", want.fetch, got.fetch);
          check_field("alu_op", 16'(want.alu_op), 16'(got.alu_op));
          check_field("operand_selects", 16'(want.selects), 16'(got.selects));
          check_field("access_enables", 16'(want.enables), 16'(got.enables));
          check_field("source_reg", 16'(want.src), 16'(got.src));
          check_field("dest_reg", 16'(want.dst), 16'(got.dst));
          check_field("immediate", 16'(want.imm), 16'(got.imm));
          check_field("writeback_select", 16'(want.wb_sel), 16'(got.wb_sel));
          check_field("address_path_selects", 16'(want.addr_sel), 16'(got.addr_sel));
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the decode and branch unit testbench: clock, reset, instruction stimulus,
// result back-pressure, watchdog and verdict. Depends on cdb_pkg and decode_result_check.

module testbench;
  import isa_fields_pkg::*;

  localparam int RANDOM_WORDS   = 600;
  localparam int WATCHDOG_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [8*cdb_pkg::CDB_IN_BYTES-1:0]  s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [8*cdb_pkg::CDB_OUT_BYTES-1:0] m_tdata;
  int   errors;
  int   pending;
  int   idle_cycles = 0;
  int   send_stretch = 0;
  bit   send_quiet = 1'b0;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cpu_decode_and_branch_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  decode_result_check i_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending)
  );

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 20);
  endfunction

  function automatic logic [15:0] random_target();
    if ($urandom_range(0, 9) == 0) begin
      return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
    end
    return 16'($urandom);
  endfunction

  // Mostly well-formed instructions with random fields, some raw noise and NOPs
  function automatic logic [15:0] random_instruction();
    logic [3:0] opc;
    logic [3:0] cnd;
    logic [3:0] ext;
    logic [3:0] lo;
    int         roll;
    cnd  = 4'($urandom);
    ext  = 4'($urandom);
    lo   = 4'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      return 16'($urandom);
    end else if (roll < 9) begin
      return 16'h0000;
    end else if (roll < 30) begin
      opc = ($urandom_range(0, 1) == 1) ? OPC_BCOND : OPC_MEM;
    end else begin
      opc = LEGAL_OPCS[$urandom_range(0, 11)];
    end
    if (opc == OPC_REG && $urandom_range(0, 9) != 0) begin
      ext = REG_EXTS[$urandom_range(0, 6)];
    end else if (opc == OPC_MEM && $urandom_range(0, 19) != 0) begin
      ext = MEM_EXTS[$urandom_range(0, 3)];
    end else if (opc == OPC_SHIFT && $urandom_range(0, 3) != 0) begin
      ext = {3'($urandom_range(0, 3)), ext[0]};
    end
    if ((opc == OPC_BCOND || (opc == OPC_MEM && ext == EXT_JCOND))
        && $urandom_range(0, 9) != 0) begin
      cnd = DEFINED_CONDS[$urandom_range(0, 7)];
    end
    return {opc, cnd, ext, lo};
  endfunction

  // Offer one word after an optional gap and hold it until taken; ends on a falling edge
  task automatic send_item(input logic [15:0] ins, input logic [3:0] flg,
                           input logic [15:0] tgt);
    int gap;
    if (send_stretch == 0) begin
      send_quiet   = ($urandom_range(0, 3) == 0);
      send_stretch = $urandom_range(20, 80);
    end
    send_stretch--;
    gap = send_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, tgt, flg, ins};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Result back-pressure: random stalls with calm stretches between
  initial begin
    int stall_left;
    int stretch;
    bit calm;
    stall_left = 0;
    stretch    = 0;
    calm       = 1'b0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (stretch == 0) begin
        calm    = ($urandom_range(0, 3) == 0);
        stretch = $urandom_range(40, 200);
      end
      stretch--;
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        m_tready <= (stall_left == 0);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Stop a hung run: count cycles in which no word moves on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    s_tvalid = 1'b0;
    s_tdata  = '0;
    rst      = 1'b1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // NOP as the very first word, before the pc has started
    send_item(16'h0000, 4'h0, 16'h0000);
    // every register-form operation, then an unassigned extension
    foreach (REG_EXTS[k]) begin
      send_item({OPC_REG, 4'($urandom), REG_EXTS[k], 4'($urandom)}, 4'($urandom), 16'h0000);
    end
    send_item({OPC_REG, 4'hF, EXT_REG_SPARE, 4'h0}, 4'h0, 16'h0000);
    // immediate forms, immediate sign bit set and clear in turn
    foreach (IMM_OPCS[k]) begin
      send_item({IMM_OPCS[k], 4'($urandom), (k % 2 == 0) ? 8'hFF : 8'h00}, 4'h0, 16'h0000);
    end
    // every shift kind and an unassigned one
    for (int k = int'(SHK_LSH); k <= int'(SHK_SPARE); k++) begin
      send_item({OPC_SHIFT, 4'h2, 3'(k), 1'b1, 4'h9}, 4'h0, 16'h0000);
    end
    send_item({OPC_MEM, 4'h1, EXT_LOAD, 4'h2}, 4'h0, 16'h0000);
    send_item({OPC_MEM, 4'h8, EXT_STOR, 4'hE}, 4'h0, 16'h0000);
    // jump and link to the top of memory wraps the pc
    send_item({OPC_MEM, 4'h0, EXT_JAL, 4'h3}, 4'hF, 16'hFFFF);
    // jump on carry set keeps the address-path selects
    send_item({OPC_MEM, COND_CS, EXT_JCOND, 4'h4}, 4'b0001, 16'h1234);
    send_item({OPC_MEM, COND_SPARE, EXT_JCOND, 4'h0}, 4'hF, 16'hBEEF);
    // branches: most negative and most positive displacement, not taken, undefined
    send_item({OPC_BCOND, COND_EQ, 8'h80}, 4'b1000, 16'h0000);
    send_item({OPC_BCOND, COND_LT, 8'h7F}, 4'b0000, 16'h0000);
    send_item({OPC_BCOND, COND_NE, 8'h10}, 4'b1000, 16'h0000);
    send_item({OPC_BCOND, COND_SPARE, 8'h05}, 4'b0101, 16'h0000);
    send_item({OPC_LUI, 4'h7, 8'hA5}, 4'h0, 16'h0000);
    send_item({OPC_SPARE, 4'h3, 8'h3C}, 4'h0, 16'h0000);
    send_item(16'hFFFF, 4'hF, 16'hFFFF);

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      send_item(random_instruction(), 4'($urandom), random_target());
    end
    s_tvalid <= 1'b0;

    // drain, then let the unit idle before the verdict
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
